>>> src/chip8_pkg.sv
package chip8_pkg;

    localparam int          MEM_BYTES  = 4096;
    localparam int          SCREEN_W   = 64;
    localparam int          SCREEN_H   = 32;
    localparam int          NUM_REGS   = 16;
    localparam logic [11:0] FONT_BASE  = 12'h050;
    localparam logic [11:0] PROG_START = 12'h200;
    localparam logic [11:0] CLR_LAST   = 12'hFFF;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_RUN  = 2'd1;
    localparam logic [1:0] MODE_ROW  = 2'd2;

    localparam logic [7:0] FONT [0:79] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    // main memory read address
    typedef enum logic [1:0] {
        MRA_PC,
        MRA_PC1,
        MRA_IDX
    } t_mra;

    // main memory write source
    typedef enum logic [2:0] {
        MW_NONE,
        MW_LOAD,
        MW_CLR,
        MW_BCD,
        MW_REG
    } t_mwr;

    // register file read address
    typedef enum logic [1:0] {
        RRA_X,
        RRA_Y,
        RRA_ZERO,
        RRA_CNT
    } t_rra;

    // register file write
    typedef enum logic [2:0] {
        RW_NONE,
        RW_VX,
        RW_VF,
        RW_COLL,
        RW_CNT
    } t_rwr;

    typedef struct packed {
        logic take;
        logic cnt_inc;
        t_mra mem_ra;
        t_mwr mem_wr;
        logic op_hi;
        logic op_lo;
        logic pc_inc;
        t_rra reg_ra;
        logic lat_a;
        logic lat_b;
        t_rwr reg_wr;
        logic exec;
        logic ret;
        logic fb_clr;
        logic fb_draw_rd;
        logic fb_draw;
        logic tick;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic [15:0] op;
        logic        key_found;
        logic        cnt_eq_x;
        logic        bcd_last;
        logic        draw_end;
        logic        clr_last;
        logic        cls_last;
    } t_dp_stat;

    function automatic logic [7:0] font_byte(input logic [11:0] a);
        logic [11:0] off;
        off = a - FONT_BASE;
        if (a >= FONT_BASE && a < FONT_BASE + 12'd80) begin
            return FONT[off[6:0]];
        end
        return 8'h00;
    endfunction

    // decimal digit sel of v: 0 hundreds, 1 tens, 2 ones
    function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
        logic [1:0]  h;
        logic [7:0]  rem;
        logic [14:0] prod;
        logic [3:0]  t;
        logic [7:0]  o;
        h    = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
        rem  = v - ((h == 2'd2) ? 8'd200 : ((h == 2'd1) ? 8'd100 : 8'd0));
        // rem < 100, so rem * 205 >> 11 is rem / 10
        prod = 15'(rem) * 15'd205;
        t    = prod[14:11];
        o    = rem - 8'(t) * 8'd10;
        case (sel)
            2'd0:    return {6'd0, h};
            2'd1:    return {4'd0, t};
            default: return o;
        endcase
    endfunction

endpackage

>>> src/chip8_datapath.sv
module chip8_datapath
    import chip8_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  logic [1:0]  i_mode,
    input  logic [11:0] i_load_address,
    input  logic [7:0]  i_load_byte,
    input  logic [15:0] i_key_states,
    input  logic [7:0]  i_random_byte,
    input  logic [4:0]  i_row_select,
    output logic [11:0] o_program_counter,
    output logic [15:0] o_last_opcode,
    output logic        o_sound_active,
    output logic [7:0]  o_delay_count,
    output logic [63:0] o_row_pixels
);

    localparam int SPW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [SPW-1:0] SP_LAST = SPW'(STACK_DEPTH - 1);

    logic [7:0]  mem [0:MEM_BYTES-1];
    logic [63:0] fb [0:SCREEN_H-1];
    logic [7:0]  regs [0:NUM_REGS-1];
    logic [11:0] stk [0:STACK_DEPTH-1];

    logic [11:0]    r_pc;
    logic [15:0]    r_idx;
    logic [15:0]    r_op;
    logic [7:0]     r_dt;
    logic [7:0]     r_st;
    logic [SPW-1:0] r_sp;
    logic [7:0]     r_a;
    logic [7:0]     r_b;
    logic [11:0]    r_cnt;
    logic           r_coll;
    logic [1:0]     r_mode;
    logic [11:0]    r_ld_addr;
    logic [7:0]     r_ld_byte;
    logic [15:0]    r_keys;
    logic [7:0]     r_rnd;
    logic [4:0]     r_row_sel;
    logic [7:0]     r_mem_q;
    logic [63:0]    r_fb_q;
    logic [7:0]     r_reg_q;
    logic [11:0]    r_stk_q;

    logic [11:0]    r_out_pc;
    logic [15:0]    r_out_op;
    logic           r_out_snd;
    logic [7:0]     r_out_dt;
    logic [63:0]    r_out_row;

    logic [3:0]     x, y, nib;
    logic [7:0]     kk;
    logic [11:0]    nnn;
    logic [11:0]    idx_addr;
    logic [11:0]    mem_ra;
    logic           mem_we;
    logic [11:0]    mem_wa;
    logic [7:0]     mem_wd;
    logic [3:0]     reg_ra;
    logic           reg_we;
    logic [3:0]     reg_wa;
    logic [7:0]     reg_wd;
    logic [5:0]     drow;
    logic [4:0]     fb_ra;
    logic [63:0]    bits;
    logic [SPW-1:0] sp_dec, sp_inc;
    logic           key_found;
    logic [3:0]     key_idx;
    logic           vx_key_down;
    logic [7:0]     result;
    logic           flag;
    logic           clr_pass;

    assign x        = r_op[11:8];
    assign y        = r_op[7:4];
    assign nib      = r_op[3:0];
    assign kk       = r_op[7:0];
    assign nnn      = r_op[11:0];
    assign idx_addr = r_idx[11:0] + r_cnt;
    assign drow     = {1'b0, r_b[4:0]} + {2'b0, r_cnt[3:0]};
    assign fb_ra    = i_cmd.fb_draw_rd ? drow[4:0] : r_row_sel;
    assign bits     = {r_mem_q, 56'd0} >> r_a[5:0];
    assign sp_dec   = (r_sp == '0) ? SP_LAST : r_sp - 1'b1;
    assign sp_inc   = (r_sp == SP_LAST) ? '0 : r_sp + 1'b1;
    assign clr_pass = (i_cmd.mem_wr == MW_CLR);
    assign vx_key_down = (r_a[7:4] == 4'd0) && r_keys[r_a[3:0]];

    always_comb begin
        key_found = 1'b0;
        key_idx   = 4'd0;
        for (int k = NUM_REGS - 1; k >= 0; k--) begin
            if (r_keys[k]) begin
                key_found = 1'b1;
                key_idx   = 4'(k);
            end
        end
    end

    always_comb begin
        result = 8'd0;
        flag   = 1'b0;
        case (r_op[15:12])
            4'h6: result = kk;
            4'h7: result = r_a + kk;
            4'h8: begin
                case (nib)
                    4'h0: result = r_b;
                    4'h1: result = r_a | r_b;
                    4'h2: result = r_a & r_b;
                    4'h3: result = r_a ^ r_b;
                    4'h4: begin
                        result = r_a + r_b;
                        flag   = ({1'b0, r_a} + {1'b0, r_b}) > 9'd255;
                    end
                    4'h5: begin
                        result = r_a - r_b;
                        flag   = r_a > r_b;
                    end
                    4'h6: begin
                        result = {1'b0, r_a[7:1]};
                        flag   = r_a[0];
                    end
                    4'h7: begin
                        result = r_b - r_a;
                        flag   = r_b > r_a;
                    end
                    4'hE: begin
                        result = {r_a[6:0], 1'b0};
                        flag   = r_a[7];
                    end
                    default: result = 8'd0;
                endcase
            end
            4'hC: result = r_rnd & kk;
            4'hF: result = (kk == 8'h07) ? r_dt : {4'd0, key_idx};
            default: result = 8'd0;
        endcase
    end

    always_comb begin
        case (i_cmd.mem_ra)
            MRA_PC1: mem_ra = r_pc + 12'd1;
            MRA_IDX: mem_ra = idx_addr;
            default: mem_ra = r_pc;
        endcase
        mem_we = 1'b1;
        mem_wa = idx_addr;
        mem_wd = r_reg_q;
        case (i_cmd.mem_wr)
            MW_LOAD: begin
                mem_wa = r_ld_addr;
                mem_wd = r_ld_byte;
            end
            MW_CLR: begin
                mem_wa = r_cnt;
                mem_wd = font_byte(r_cnt);
            end
            MW_BCD: mem_wd = bcd_digit(r_a, r_cnt[1:0]);
            MW_REG: mem_wd = r_reg_q;
            default: mem_we = 1'b0;
        endcase
    end

    always_comb begin
        case (i_cmd.reg_ra)
            RRA_Y:    reg_ra = y;
            RRA_ZERO: reg_ra = 4'd0;
            RRA_CNT:  reg_ra = r_cnt[3:0];
            default:  reg_ra = x;
        endcase
        reg_we = 1'b1;
        reg_wa = x;
        reg_wd = result;
        case (i_cmd.reg_wr)
            RW_VX: begin
                reg_wa = x;
                reg_wd = result;
            end
            RW_VF: begin
                reg_wa = 4'hF;
                reg_wd = {7'd0, flag};
            end
            RW_COLL: begin
                reg_wa = 4'hF;
                reg_wd = {7'd0, r_coll};
            end
            RW_CNT: begin
                reg_wa = r_cnt[3:0];
                reg_wd = r_mem_q;
            end
            default: begin
                reg_we = clr_pass && (r_cnt[11:4] == 8'd0);
                reg_wa = r_cnt[3:0];
                reg_wd = 8'd0;
            end
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_mem_q <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if ((clr_pass && r_cnt[11:5] == 7'd0) || i_cmd.fb_clr) begin
            fb[r_cnt[4:0]] <= 64'd0;
        end else if (i_cmd.fb_draw) begin
            fb[drow[4:0]] <= r_fb_q ^ bits;
        end
        r_fb_q <= fb[fb_ra];
    end

    always_ff @(posedge i_clk) begin
        if (reg_we) begin
            regs[reg_wa] <= reg_wd;
        end
        r_reg_q <= regs[reg_ra];
    end

    always_ff @(posedge i_clk) begin
        if (clr_pass && r_cnt < 12'(STACK_DEPTH)) begin
            stk[r_cnt[SPW-1:0]] <= 12'd0;
        end else if (i_cmd.exec && r_op[15:12] == 4'h2) begin
            stk[r_sp] <= r_pc;
        end
        r_stk_q <= stk[sp_dec];
    end

    // input capture and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_mode    <= i_mode;
            r_ld_addr <= i_load_address;
            r_ld_byte <= i_load_byte;
            r_keys    <= i_key_states;
            r_rnd     <= i_random_byte;
            r_row_sel <= i_row_select;
        end
        if (i_cmd.lat_a) begin
            r_a <= r_reg_q;
        end
        if (i_cmd.lat_b) begin
            r_b <= r_reg_q;
        end
        if (i_cmd.finish) begin
            r_out_pc  <= r_pc;
            r_out_op  <= r_op;
            r_out_snd <= (r_st != 8'd0);
            r_out_dt  <= r_dt;
            r_out_row <= (r_mode == MODE_ROW) ? r_fb_q : 64'd0;
        end
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= PROG_START;
            r_idx  <= 16'd0;
            r_op   <= 16'd0;
            r_dt   <= 8'd0;
            r_st   <= 8'd0;
            r_sp   <= '0;
            r_cnt  <= 12'd0;
            r_coll <= 1'b0;
        end else begin
            if (i_cmd.op_hi) begin
                r_op[15:8] <= r_mem_q;
            end
            if (i_cmd.op_lo) begin
                r_op[7:0] <= r_mem_q;
            end
            if (i_cmd.pc_inc) begin
                r_pc <= r_pc + 12'd2;
            end
            if (i_cmd.ret) begin
                r_pc <= r_stk_q;
            end
            if (i_cmd.exec) begin
                r_cnt  <= 12'd0;
                r_coll <= 1'b0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + 12'd1;
            end
            if (i_cmd.fb_draw && ((r_fb_q & bits) != 64'd0)) begin
                r_coll <= 1'b1;
            end
            if (i_cmd.tick) begin
                if (r_dt != 8'd0) begin
                    r_dt <= r_dt - 8'd1;
                end
                if (r_st != 8'd0) begin
                    r_st <= r_st - 8'd1;
                end
            end
            if (i_cmd.exec) begin
                case (r_op[15:12])
                    4'h0: begin
                        if (r_op == 16'h00EE) begin
                            r_sp <= sp_dec;
                        end
                    end
                    4'h1: r_pc <= nnn;
                    4'h2: begin
                        r_sp <= sp_inc;
                        r_pc <= nnn;
                    end
                    4'h3: if (r_a == kk) r_pc <= r_pc + 12'd2;
                    4'h4: if (r_a != kk) r_pc <= r_pc + 12'd2;
                    4'h5: if (r_a == r_b) r_pc <= r_pc + 12'd2;
                    4'h9: if (r_a != r_b) r_pc <= r_pc + 12'd2;
                    4'hA: r_idx <= {4'd0, nnn};
                    4'hB: r_pc <= nnn + {4'd0, r_a};
                    4'hE: begin
                        if ((kk == 8'h9E && vx_key_down) || (kk == 8'hA1 && !vx_key_down)) begin
                            r_pc <= r_pc + 12'd2;
                        end
                    end
                    4'hF: begin
                        case (kk)
                            8'h0A: if (!key_found) r_pc <= r_pc - 12'd2;
                            8'h15: r_dt <= r_a;
                            8'h18: r_st <= r_a;
                            8'h1E: r_idx <= r_idx + {8'd0, r_a};
                            8'h29: r_idx <= {4'd0, FONT_BASE} + {6'd0, r_a, 2'b0}
                                          + {8'd0, r_a};
                            default: r_idx <= r_idx;
                        endcase
                    end
                    default: r_pc <= r_pc;
                endcase
            end
        end
    end

    assign o_stat.op        = r_op;
    assign o_stat.key_found = key_found;
    assign o_stat.cnt_eq_x  = (r_cnt == {8'd0, x});
    assign o_stat.bcd_last  = (r_cnt[1:0] == 2'd2);
    assign o_stat.draw_end  = (r_cnt == {8'd0, nib}) || drow[5];
    assign o_stat.clr_last  = (r_cnt == CLR_LAST);
    assign o_stat.cls_last  = (r_cnt[4:0] == 5'd31);

    assign o_program_counter = r_out_pc;
    assign o_last_opcode     = r_out_op;
    assign o_sound_active    = r_out_snd;
    assign o_delay_count     = r_out_dt;
    assign o_row_pixels      = r_out_row;

endmodule

>>> src/chip8_ctrl.sv
module chip8_ctrl
    import chip8_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_mode,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_LOAD, S_ROW, S_F0, S_F1, S_F2, S_RX, S_RY, S_RB,
        S_EXEC, S_RET, S_WBX, S_CLS, S_DR, S_DW, S_DVF, S_BCD, S_STR, S_STW,
        S_LDR, S_LDW, S_TICK, S_DONE
    } t_state;

    t_state      r_state, n_state;
    logic        r_out_valid;
    logic [3:0]  hi;
    logic [7:0]  kk;
    logic [3:0]  nib;
    logic        flag_op;
    logic        wbx;
    logic        finishing;

    assign hi  = i_stat.op[15:12];
    assign kk  = i_stat.op[7:0];
    assign nib = i_stat.op[3:0];

    assign flag_op = (hi == 4'h8) && (nib inside {4'h4, 4'h5, 4'h6, 4'h7, 4'hE});
    always_comb begin
        case (hi)
            4'h6, 4'h7, 4'hC: wbx = 1'b1;
            4'h8:             wbx = (nib inside {[4'h0:4'h7], 4'hE});
            4'hF:             wbx = (kk == 8'h07) || (kk == 8'h0A && i_stat.key_found);
            default:          wbx = 1'b0;
        endcase
    end

    assign finishing = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                o_cmd.mem_wr  = MW_CLR;
                o_cmd.cnt_inc = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    case (i_mode)
                        MODE_LOAD: n_state = S_LOAD;
                        MODE_RUN:  n_state = S_F0;
                        MODE_ROW:  n_state = S_ROW;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_LOAD: begin
                o_cmd.mem_wr = MW_LOAD;
                n_state      = S_DONE;
            end
            S_ROW: n_state = S_DONE;
            S_F0: begin
                o_cmd.mem_ra = MRA_PC;
                n_state      = S_F1;
            end
            S_F1: begin
                o_cmd.mem_ra = MRA_PC1;
                o_cmd.op_hi  = 1'b1;
                n_state      = S_F2;
            end
            S_F2: begin
                o_cmd.op_lo  = 1'b1;
                o_cmd.pc_inc = 1'b1;
                n_state      = S_RX;
            end
            S_RX: begin
                o_cmd.reg_ra = (hi == 4'hB) ? RRA_ZERO : RRA_X;
                n_state      = S_RY;
            end
            S_RY: begin
                o_cmd.reg_ra = RRA_Y;
                o_cmd.lat_a  = 1'b1;
                n_state      = S_RB;
            end
            S_RB: begin
                o_cmd.lat_b = 1'b1;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (flag_op) o_cmd.reg_wr = RW_VF;
                if (i_stat.op == 16'h00E0) begin
                    n_state = S_CLS;
                end else if (i_stat.op == 16'h00EE) begin
                    n_state = S_RET;
                end else if (hi == 4'hD) begin
                    n_state = S_DR;
                end else if (hi == 4'hF && kk == 8'h33) begin
                    n_state = S_BCD;
                end else if (hi == 4'hF && kk == 8'h55) begin
                    n_state = S_STR;
                end else if (hi == 4'hF && kk == 8'h65) begin
                    n_state = S_LDR;
                end else if (wbx) begin
                    n_state = S_WBX;
                end else begin
                    n_state = S_TICK;
                end
            end
            S_RET: begin
                o_cmd.ret = 1'b1;
                n_state   = S_TICK;
            end
            S_WBX: begin
                o_cmd.reg_wr = RW_VX;
                n_state      = S_TICK;
            end
            S_CLS: begin
                o_cmd.fb_clr  = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                if (i_stat.cls_last) n_state = S_TICK;
            end
            S_DR: begin
                o_cmd.fb_draw_rd = 1'b1;
                o_cmd.mem_ra     = MRA_IDX;
                n_state          = i_stat.draw_end ? S_DVF : S_DW;
            end
            S_DW: begin
                o_cmd.fb_draw_rd = 1'b1;
                o_cmd.fb_draw    = 1'b1;
                o_cmd.cnt_inc    = 1'b1;
                n_state          = S_DR;
            end
            S_DVF: begin
                o_cmd.reg_wr = RW_COLL;
                n_state      = S_TICK;
            end
            S_BCD: begin
                o_cmd.mem_wr  = MW_BCD;
                o_cmd.cnt_inc = 1'b1;
                if (i_stat.bcd_last) n_state = S_TICK;
            end
            S_STR: begin
                o_cmd.reg_ra = RRA_CNT;
                n_state      = S_STW;
            end
            S_STW: begin
                o_cmd.mem_wr  = MW_REG;
                o_cmd.cnt_inc = 1'b1;
                n_state       = i_stat.cnt_eq_x ? S_TICK : S_STR;
            end
            S_LDR: begin
                o_cmd.mem_ra = MRA_IDX;
                n_state      = S_LDW;
            end
            S_LDW: begin
                o_cmd.reg_wr  = RW_CNT;
                o_cmd.cnt_inc = 1'b1;
                n_state       = i_stat.cnt_eq_x ? S_TICK : S_LDR;
            end
            S_TICK: begin
                o_cmd.tick = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (finishing) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (finishing) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> src/chip8_instruction_core.sv
// CHIP-8 core: each request loads one memory byte (mode 0), runs one machine cycle
// (mode 1) or reads one video row (mode 2), and returns one result holding pc, the
// last opcode, the timers and, for mode 2, the row. After reset a clearing pass
// writes main memory (zeros plus the hex font), the frame buffer, the registers and
// the return stack, with in_ready low. The unused mode 3 only returns a result. A
// machine cycle runs through the fetch/decode sequencer and the one read port each
// of main memory and the register file, with one more step when it writes Vx or
// returns from a subroutine; 00E0 adds a row sweep, Dxyn a read and a write step per
// sprite row drawn plus a final read step and the VF write, Fx33 one write per digit,
// Fx55 and Fx65 a read and a write step per register.
// The next request is taken while a result waits in the output register.
module chip8_instruction_core
    import chip8_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [11:0] i_load_address,
    input  logic [7:0]  i_load_byte,
    input  logic [15:0] i_key_states,
    input  logic [7:0]  i_random_byte,
    input  logic [4:0]  i_row_select,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [11:0] o_program_counter,
    output logic [15:0] o_last_opcode,
    output logic        o_sound_active,
    output logic [7:0]  o_delay_count,
    output logic [63:0] o_row_pixels
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    chip8_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    chip8_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_mode            (i_mode),
        .i_load_address    (i_load_address),
        .i_load_byte       (i_load_byte),
        .i_key_states      (i_key_states),
        .i_random_byte     (i_random_byte),
        .i_row_select      (i_row_select),
        .o_program_counter (o_program_counter),
        .o_last_opcode     (o_last_opcode),
        .o_sound_active    (o_sound_active),
        .o_delay_count     (o_delay_count),
        .o_row_pixels      (o_row_pixels)
    );

    // clearing pass runs right after reset
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_in_ready)
        else $error("request taken during clearing pass");

    // a result appears only from a busy core
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result raised while idle");

    // one request at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second request taken while busy");

endmodule

>>> sim/chip8_instruction_core_test.sv
`timescale 1ns / 1ps

module chip8_instruction_core_test;
    import chip8_pkg::*;

    localparam int STACK_LEN = 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_mode;
    logic [11:0] i_load_address;
    logic [7:0]  i_load_byte;
    logic [15:0] i_key_states;
    logic [7:0]  i_random_byte;
    logic [4:0]  i_row_select;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [11:0] o_program_counter;
    logic [15:0] o_last_opcode;
    logic        o_sound_active;
    logic [7:0]  o_delay_count;
    logic [63:0] o_row_pixels;

    chip8_instruction_core #(.STACK_DEPTH(STACK_LEN)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_mode(i_mode), .i_load_address(i_load_address), .i_load_byte(i_load_byte),
        .i_key_states(i_key_states), .i_random_byte(i_random_byte),
        .i_row_select(i_row_select),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_program_counter(o_program_counter), .o_last_opcode(o_last_opcode),
        .o_sound_active(o_sound_active), .o_delay_count(o_delay_count),
        .o_row_pixels(o_row_pixels)
    );

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] addr;
        logic [7:0]  data;
        logic [15:0] keys;
        logic [7:0]  rnd;
        logic [4:0]  row;
    } t_request;

    typedef struct packed {
        logic [11:0] pc;
        logic [15:0] op;
        logic        snd;
        logic [7:0]  dly;
        logic [63:0] pix;
    } t_status;

    // model state
    logic [7:0]  mem [0:4095];
    logic [63:0] fb [0:31];
    logic [7:0]  v [0:15];
    logic [11:0] stk [0:STACK_LEN-1];
    int          sp;
    logic [11:0] pc;
    logic [15:0] idx;
    logic [15:0] opc;
    logic [7:0]  dt, st;

    t_status expected_q[$];
    int      errors;
    int      shown;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function automatic bit key_down(logic [15:0] keys, logic [7:0] k);
        return k < 16 && keys[k[3:0]];
    endfunction

    function automatic void machine_cycle(logic [15:0] keys, logic [7:0] rnd);
        logic [15:0] op;
        logic [3:0]  x, y;
        logic [7:0]  kk, vx, vy;
        logic [11:0] nnn;
        logic [63:0] bits;
        int          xs, ys;
        bit          found;
        op = {mem[pc], mem[pc + 12'd1]};
        opc = op;
        pc = pc + 12'd2;
        x = op[11:8]; y = op[7:4]; kk = op[7:0]; nnn = op[11:0];
        vx = v[x]; vy = v[y];
        case (op[15:12])
            4'h0: begin
                if (op == 16'h00E0) begin
                    for (int r = 0; r < 32; r++) fb[r] = '0;
                end else if (op == 16'h00EE) begin
                    sp = (sp == 0) ? STACK_LEN - 1 : sp - 1;
                    pc = stk[sp];
                end
            end
            4'h1: pc = nnn;
            4'h2: begin
                stk[sp] = pc;
                sp = (sp + 1) % STACK_LEN;
                pc = nnn;
            end
            4'h3: if (vx == kk) pc = pc + 12'd2;
            4'h4: if (vx != kk) pc = pc + 12'd2;
            4'h5: if (vx == vy) pc = pc + 12'd2;
            4'h6: v[x] = kk;
            4'h7: v[x] = vx + kk;
            4'h8: begin
                case (op[3:0])
                    4'h0: v[x] = vy;
                    4'h1: v[x] = vx | vy;
                    4'h2: v[x] = vx & vy;
                    4'h3: v[x] = vx ^ vy;
                    4'h4: begin v[15] = (9'(vx) + 9'(vy) > 255); v[x] = vx + vy; end
                    4'h5: begin v[15] = (vx > vy); v[x] = vx - vy; end
                    4'h6: begin v[15] = vx[0]; v[x] = vx >> 1; end
                    4'h7: begin v[15] = (vy > vx); v[x] = vy - vx; end
                    4'hE: begin v[15] = vx[7]; v[x] = vx << 1; end
                    default: ;
                endcase
            end
            4'h9: if (vx != vy) pc = pc + 12'd2;
            4'hA: idx = {4'd0, nnn};
            4'hB: pc = 12'(v[0]) + nnn;
            4'hC: v[x] = rnd & kk;
            4'hD: begin
                xs = vx % 64; ys = vy % 32;
                v[15] = 0;
                for (int r = 0; r < op[3:0]; r++) begin
                    if (ys + r < 32) begin
                        bits = {mem[12'(idx + r)], 56'd0} >> xs;
                        if ((fb[ys + r] & bits) != 0) v[15] = 1;
                        fb[ys + r] ^= bits;
                    end
                end
            end
            4'hE: begin
                if (kk == 8'h9E) begin
                    if (key_down(keys, vx)) pc = pc + 12'd2;
                end else if (kk == 8'hA1) begin
                    if (!key_down(keys, vx)) pc = pc + 12'd2;
                end
            end
            default: begin
                case (kk)
                    8'h07: v[x] = dt;
                    8'h0A: begin
                        found = 0;
                        for (int k = 0; k < 16; k++) begin
                            if (!found && keys[k]) begin
                                v[x] = 8'(k);
                                found = 1;
                            end
                        end
                        if (!found) pc = pc - 12'd2;
                    end
                    8'h15: dt = vx;
                    8'h18: st = vx;
                    8'h1E: idx = idx + 16'(vx);
                    8'h29: idx = 16'(FONT_BASE) + 16'd5 * 16'(vx);
                    8'h33: begin
                        mem[12'(idx)]     = vx / 100;
                        mem[12'(idx + 1)] = (vx / 10) % 10;
                        mem[12'(idx + 2)] = vx % 10;
                    end
                    8'h55: for (int i = 0; i <= x; i++) mem[12'(idx + i)] = v[i];
                    8'h65: for (int i = 0; i <= x; i++) v[i] = mem[12'(idx + i)];
                    default: ;
                endcase
            end
        endcase
        if (dt != 0) dt--;
        if (st != 0) st--;
    endfunction

    function automatic t_status apply_request(t_request rq);
        t_status s;
        s.pix = '0;
        if (rq.mode == MODE_LOAD) mem[rq.addr] = rq.data;
        else if (rq.mode == MODE_RUN) machine_cycle(rq.keys, rq.rnd);
        else if (rq.mode == MODE_ROW) s.pix = fb[rq.row];
        s.pc = pc; s.op = opc; s.snd = (st != 0); s.dly = dt;
        return s;
    endfunction

    task automatic send_request(t_request rq);
        t_status s;
        repeat ($urandom_range(0, 6)) @(negedge i_clk);
        i_mode = rq.mode; i_load_address = rq.addr; i_load_byte = rq.data;
        i_key_states = rq.keys; i_random_byte = rq.rnd; i_row_select = rq.row;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        s = apply_request(rq);
        expected_q.push_back(s);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    function automatic t_request mk(logic [1:0] m, logic [11:0] a, logic [7:0] d);
        t_request rq;
        rq.mode = m; rq.addr = a; rq.data = d;
        rq.keys = 16'($urandom); rq.rnd = 8'($urandom); rq.row = 5'($urandom);
        return rq;
    endfunction

    task automatic load_word(logic [11:0] a, logic [15:0] w);
        send_request(mk(MODE_LOAD, a, w[15:8]));
        send_request(mk(MODE_LOAD, a + 12'd1, w[7:0]));
    endtask

    // receiver: random stalls, compare against oldest expectation
    initial begin
        t_status exp_s, got;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            i_out_ready = 1'b0;
            if ($urandom_range(0, 3) != 0) repeat ($urandom_range(0, 6)) @(negedge i_clk);
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            got = {o_program_counter, o_last_opcode, o_sound_active, o_delay_count,
                   o_row_pixels};
            if (expected_q.size() == 0) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("unexpected result pc=%h op=%h", got.pc, got.op);
                end
            end else begin
                exp_s = expected_q.pop_front();
                if (got !== exp_s) begin
                    errors++;
                    if (shown < 10) begin
                        shown++;
                        $display("mismatch: exp pc=%h op=%h snd=%b dly=%h pix=%h",
                                 exp_s.pc, exp_s.op, exp_s.snd, exp_s.dly, exp_s.pix);
                        $display("          got pc=%h op=%h snd=%b dly=%h pix=%h",
                                 got.pc, got.op, got.snd, got.dly, got.pix);
                    end
                end
            end
        end
    end

    // directed program; expected status typed in where obvious
    typedef struct {
        t_request rq;
        bit       chk;
        t_status  st;
    } t_row;

    t_row directed [$];

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // random program content: opcodes weighted toward useful ones
    function automatic logic [15:0] rand_opcode();
        logic [15:0] w;
        w = 16'($urandom);
        case ($urandom_range(0, 15))
            0: w = 16'h00E0;
            1: w = {4'h2, 12'h200 | 12'($urandom_range(0, 63) * 2)};
            2: w = 16'h00EE;
            3: w = {4'h1, 12'h200 | 12'($urandom_range(0, 63) * 2)};
            4: w = {4'hD, w[11:0]};
            5: w = {4'hF, w[11:8], 8'h0A};
            6: w = {4'hF, w[11:8], 8'h33};
            7: w = {4'hF, w[11:8], ($urandom_range(0, 1) ? 8'h55 : 8'h65)};
            8: w = {4'hF, w[11:8], 8'h29};
            9: w = {4'hF, w[11:8], ($urandom_range(0, 1) ? 8'h15 : 8'h18)};
            10: w = {4'h8, w[11:4], 4'($urandom_range(0, 15))};
            11: w = {4'hE, w[11:8], ($urandom_range(0, 1) ? 8'h9E : 8'hA1)};
            12: w = {4'hA, 4'h3, w[7:0]};
            13: w = {4'hB, 4'h2, w[7:0]};
            default: ;
        endcase
        return w;
    endfunction

    initial begin
        t_request rq;
        t_status  s;
        int       sent;
        i_rst_n = 1'b0; i_in_valid = 1'b0;
        i_mode = MODE_LOAD; i_load_address = '0; i_load_byte = '0;
        i_key_states = '0; i_random_byte = '0; i_row_select = '0;
        errors = 0; shown = 0;
        for (int a = 0; a < 4096; a++) mem[a] = 8'h00;
        for (int a = 0; a < 80; a++) mem[FONT_BASE + a] = FONT[a];
        for (int r = 0; r < 32; r++) fb[r] = '0;
        for (int r = 0; r < 16; r++) v[r] = '0;
        for (int r = 0; r < STACK_LEN; r++) stk[r] = '0;
        sp = 0; pc = PROG_START; idx = '0; opc = '0; dt = '0; st = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: rows after reset, then a short program
        directed.push_back('{mk(MODE_ROW, 0, 0), 1, '{12'h200, 16'h0, 1'b0, 8'h0, 64'h0}});
        directed.push_back('{mk(2'd3, 12'hFFF, 8'hFF), 1, '{12'h200, 16'h0, 1'b0, 8'h0, 64'h0}});
        directed.push_back('{mk(MODE_LOAD, 12'hFFF, 8'hFF), 1,
                             '{12'h200, 16'h0, 1'b0, 8'h0, 64'h0}});
        directed.push_back('{mk(MODE_RUN, 0, 0), 1, '{12'h202, 16'h0, 1'b0, 8'h0, 64'h0}});
        foreach (directed[i]) begin
            send_request(directed[i].rq);
            s = expected_q[$];
            if (directed[i].chk && s !== directed[i].st) begin
                errors++;
                $display("model disagrees with directed row %0d", i);
            end
        end
        // program at 0x202: font sprite at right/bottom edge, flags, bcd, store/load
        begin
            logic [15:0] prog [$];
            prog = '{16'h60FF, 16'h61FF, 16'h8014, 16'h8F15, 16'h8017, 16'h800E,
                     16'h8006, 16'h623F, 16'h631F, 16'hF029, 16'hD23F, 16'hD23F,
                     16'hF033, 16'hFF55, 16'hFF65, 16'hF50A, 16'hF615, 16'hF718,
                     16'hE09E, 16'hE0A1, 16'hC0FF, 16'h2FFE, 16'h00E0};
            foreach (prog[i]) load_word(12'h202 + 12'(2 * i), prog[i]);
            load_word(12'hFFE, 16'h00EE);
            for (int i = 0; i < prog.size() + 3; i++) begin
                rq = mk(MODE_RUN, 0, 0);
                if (i == 15) rq.keys = 16'h0;
                send_request(rq);
            end
            for (int r = 0; r < 32; r += 31) begin
                rq = mk(MODE_ROW, 0, 0);
                rq.row = 5'(r);
                send_request(rq);
            end
        end

        // pause until everything has drained
        while (expected_q.size() != 0) @(negedge i_clk);

        sent = 0;
        while (sent < 1600) begin
            if ($urandom_range(0, 7) == 0) begin
                // fresh burst of program at a random even address, then jump there
                logic [11:0] base;
                base = 12'h200 | 12'($urandom_range(0, 63) * 2);
                for (int i = 0; i < 8; i++) begin
                    load_word(base + 12'(2 * i), rand_opcode());
                    sent += 2;
                end
                load_word(pc, {4'h1, base});
                sent += 2;
            end
            rq = mk(2'($urandom_range(0, 9) < 7 ? MODE_RUN : $urandom_range(0, 3)),
                    12'($urandom), 8'($urandom));
            if ($urandom_range(0, 2) == 0) rq.keys = 16'h0;
            if (rq.mode == MODE_LOAD && $urandom_range(0, 1))
                rq.addr = 12'h200 | 12'($urandom_range(0, 127));
            send_request(rq);
            sent++;
            if (sent % 400 == 0) while (expected_q.size() != 0) @(negedge i_clk);
        end

        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> chip8_instruction_core.f
src/chip8_pkg.sv
src/chip8_datapath.sv
src/chip8_ctrl.sv
src/chip8_instruction_core.sv
sim/chip8_instruction_core_test.sv
